// ===== src/hsec_pkg.sv =====
// ----------------------------------------------------------------------------
// hsec_pkg
// Shared types, constants and code functions of the SEC memory check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsec_pkg;

	localparam int WORD_W         = 64;
	localparam int ADDR_W         = 10;
	localparam int CHK_W          = 7;
	localparam int BITS_PER_BYTE  = 8;
	localparam int ADDR_BITS_DEF  = 10;
	localparam int WORD_BYTES_DEF = 8;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAN   = 3'd0,
		ST_FIXED   = 3'd1,
		ST_CHK_ERR = 3'd2,
		ST_BAD_SYN = 3'd3,
		ST_NO_BITS = 3'd4
	} status_t;

	// one entry of the check-bit store
	typedef struct packed {
		logic             valid;
		logic [CHK_W-1:0] check;
	} entry_t;

	typedef logic [CHK_W-1:0] pos_tab_t [WORD_W];

	function automatic logic is_pow2(input int v);
		return (v != 0) && ((v & (v - 1)) == 0);
	endfunction

	// codeword position of each data index, skipping the powers of two
	function automatic pos_tab_t build_pos();
		pos_tab_t t;
		int       d;
		d = 0;
		for (int p = 1; p < (1 << CHK_W); p++) begin
			if (!is_pow2(p) && d < WORD_W) begin
				t[d] = CHK_W'(p);
				d++;
			end
		end
		return t;
	endfunction

	localparam pos_tab_t DATA_POS = build_pos();

	function automatic int num_check_bits(input int data_bits);
		int r;
		r = 0;
		for (int i = 0; i < 8; i++) begin
			if ((1 << r) < data_bits + r + 1) r++;
		end
		return r;
	endfunction

	// xor of the positions of all set data bits
	function automatic logic [CHK_W-1:0] code_of(input logic [WORD_W-1:0] w,
			input int data_bits);
		logic [CHK_W-1:0] syn;
		syn = '0;
		for (int d = 0; d < WORD_W; d++) begin
			if (d < data_bits) begin
				if (w[data_bits-1-d]) syn = syn ^ DATA_POS[d];
			end
		end
		return syn;
	endfunction

endpackage

// ===== src/hsec_req_if.sv =====
// ----------------------------------------------------------------------------
// hsec_req_if
// Request channel: opcode, word address and data word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hsec_req_if import hsec_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [ADDR_W-1:0] word_addr;
	logic [WORD_W-1:0] word_in;

	modport source(output valid, opcode, word_addr, word_in, input ready);
	modport sink(input valid, opcode, word_addr, word_in, output ready);
endinterface

// ===== src/hsec_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hsec_rsp_if
// Response channel: data word, status and syndrome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hsec_rsp_if import hsec_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word_out;
	logic [2:0]        status;
	logic [CHK_W-1:0]  syndrome;

	modport source(output valid, word_out, status, syndrome, input ready);
	modport sink(input valid, word_out, status, syndrome, output ready);
endinterface

// ===== src/hsec_store.sv =====
// ----------------------------------------------------------------------------
// hsec_store
// Check-bit store with valid flag per entry, registered read and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsec_store import hsec_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [CHK_W-1:0]     wr_check,
	output entry_t               rd_entry,
	output logic                 clr_busy
);

	localparam int DEPTH = 1 << ADDR_BITS;

	entry_t               mem [DEPTH];
	entry_t               rd_q;
	logic [ADDR_BITS:0]   clr_cnt_q;

	assign clr_busy = !clr_cnt_q[ADDR_BITS];
	assign rd_entry = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clr_busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy) begin
			mem[clr_cnt_q[ADDR_BITS-1:0]] <= '0;
		end else if (wr_en) begin
			mem[addr] <= '{valid: 1'b1, check: wr_check};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

endmodule

// ===== src/hsec_check.sv =====
// ----------------------------------------------------------------------------
// hsec_check
// Syndrome, classification and single data-bit correction of one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsec_check import hsec_pkg::*; #(
	parameter int WORD_BYTES = WORD_BYTES_DEF
) (
	input  op_t               op,
	input  logic [WORD_W-1:0] word,
	input  logic [CHK_W-1:0]  code,
	input  entry_t            entry,
	output logic [WORD_W-1:0] word_out,
	output status_t           status,
	output logic [CHK_W-1:0]  syndrome
);

	localparam int               DATA_BITS = WORD_BYTES * BITS_PER_BYTE;
	localparam int               CHK_BITS  = num_check_bits(DATA_BITS);
	localparam logic [CHK_W-1:0] RMASK     = CHK_W'((1 << CHK_BITS) - 1);
	localparam logic [CHK_W-1:0] CODE_LEN  = CHK_W'(DATA_BITS + CHK_BITS);

	logic [CHK_W-1:0]  syn;
	logic [WORD_W-1:0] flip;

	assign syn = code ^ (entry.check & RMASK);

	// one compare per data bit against its codeword position
	always_comb begin
		flip = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (b < DATA_BITS) flip[b] = (syn == DATA_POS[DATA_BITS-1-b]);
		end
	end

	always_comb begin
		word_out = word;
		status   = ST_CLEAN;
		syndrome = syn;
		if (op == OP_WRITE) begin
			syndrome = code;
		end else if (!entry.valid) begin
			status   = ST_NO_BITS;
			syndrome = '0;
		end else if (syn == '0) begin
			status = ST_CLEAN;
		end else if ((syn & (syn - 1'b1)) == '0) begin
			status = ST_CHK_ERR;
		end else if (syn > CODE_LEN) begin
			status = ST_BAD_SYN;
		end else begin
			status   = ST_FIXED;
			word_out = word ^ flip;
		end
	end

endmodule

// ===== src/hamming_sec_memory_check.sv =====
// ----------------------------------------------------------------------------
// hamming_sec_memory_check: SEC (71,64) check with side-stored check bits
// Pipeline: stage-one registers and store read, then output register.
// Throughput: one transaction per cycle, set by the single store access,
// unless the response stalls. Reset: a sweep clears every store entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hamming_sec_memory_check import hsec_pkg::*; #(
	parameter int ADDR_BITS  = ADDR_BITS_DEF,
	parameter int WORD_BYTES = WORD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hsec_req_if.sink   req,
	hsec_rsp_if.source rsp
);

	localparam int DATA_BITS = WORD_BYTES * BITS_PER_BYTE;

	logic                 acc;
	logic                 adv_s1;
	logic                 clr_busy;
	op_t                  req_op;
	logic [CHK_W-1:0]     code_in;
	logic [ADDR_BITS-1:0] addr;
	entry_t               rd_entry;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [WORD_W-1:0]    word_s1;
	logic [CHK_W-1:0]     code_s1;

	logic [WORD_W-1:0]    chk_word;
	status_t              chk_status;
	logic [CHK_W-1:0]     chk_syn;

	logic                 out_valid_q;
	logic [WORD_W-1:0]    word_q;
	status_t              status_q;
	logic [CHK_W-1:0]     syn_q;

	assign req_op  = op_t'(req.opcode);
	assign addr    = ADDR_BITS'(req.word_addr);
	assign code_in = code_of(req.word_in, DATA_BITS);

	assign adv_s1    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !clr_busy && (!valid_s1 || adv_s1);
	assign acc       = req.valid && req.ready;

	hsec_store #(
		.ADDR_BITS(ADDR_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (acc && req_op == OP_WRITE),
		.rd_en    (acc && req_op == OP_READ),
		.addr     (addr),
		.wr_check (code_in),
		.rd_entry (rd_entry),
		.clr_busy (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= req_op;
			word_s1 <= req.word_in;
			code_s1 <= code_in;
		end
	end

	hsec_check #(
		.WORD_BYTES(WORD_BYTES)
	) u_check (
		.op       (op_s1),
		.word     (word_s1),
		.code     (code_s1),
		.entry    (rd_entry),
		.word_out (chk_word),
		.status   (chk_status),
		.syndrome (chk_syn)
	);

	// output register, refilled in the cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_q   <= chk_word;
			status_q <= chk_status;
			syn_q    <= chk_syn;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.word_out = word_q;
	assign rsp.status   = status_q;
	assign rsp.syndrome = syn_q;

`ifndef ASSERT_OFF
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !req.ready)
		else $error("request taken during store clearing");

	a_s1_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> rsp.valid)
		else $error("stage one result lost");

	a_fixed_syndrome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FIXED |->
			(rsp.syndrome & (rsp.syndrome - 1'b1)) != '0)
		else $error("data bit fixed on a check-bit syndrome");

	a_no_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_NO_BITS |-> rsp.syndrome == '0)
		else $error("nonzero syndrome without stored bits");
`endif

endmodule
